### hdl/qte_pkg.sv
// Shared constants and helpers for the quaternion to Euler angle block.
// No dependencies; used by every module under hdl.
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int QW    = 16;          // quaternion component width
  localparam int PRODW = 2 * QW;      // one product
  localparam int SUMW  = PRODW + 2;   // doubled sum of two products
  localparam int MAGW  = 28;          // |pitch sine| below one
  localparam int SQW   = 29;          // square root result bits
  localparam int RADW  = 57;          // radicand, up to 2^56
  localparam int CW    = SUMW + 2;    // CORDIC x/y with gain headroom
  localparam int SQ_CELLS = SQW;
  localparam int PAYW  = 5 * SUMW + 1;

  localparam logic signed [SUMW-1:0] Q_ONE = SUMW'(64'sd1 <<< 28);
  localparam logic signed [SUMW-1:0] Q_NEG = -Q_ONE;

  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // atan(2^-i) rounded half up to pi = 2^(abits-1)
  function automatic logic [31:0] atan_const(input int i, input int abits);
    int s;
    s = 32 - abits;
    return (ATAN_TAB[i] + (32'd1 << (s - 1))) >> s;
  endfunction

endpackage

### hdl/quaternion_to_euler_angles.sv
// Top level: quaternion (Q2.14) to negated roll, pitch, negated yaw binary angles.
// Depends on qte_pkg, qte_sqrt_cell and qte_cordic_cell.
//
// Fully pipelined: one transaction may start every cycle (busy_o is always low), and
// its result appears on the done_o strobe. The pipeline runs through the product and
// sum stages, the 1 - sin^2 registers, a 29-cell square root chain for the pitch cosine,
// a quadrant pre-rotation register, one cell per CORDIC stage and an output register.
// Results are shown for a single cycle and cannot be held off.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_BITS    = qte_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  output logic                done_o,
  output logic signed [15:0]  roll_angle_o,
  output logic signed [15:0]  pitch_angle_o,
  output logic signed [15:0]  yaw_angle_o,
  output logic                pitch_clamped_o
);
  localparam int N    = (CORDIC_STAGES < qte_pkg::ATAN_ENTRIES) ?
                        CORDIC_STAGES : qte_pkg::ATAN_ENTRIES;
  localparam int AB   = ANGLE_BITS;
  localparam int ZW   = AB + 2;
  localparam int PW   = ((AB > 16) ? AB : 16) + 4;
  localparam int SW   = qte_pkg::SUMW;
  localparam int CW   = qte_pkg::CW;
  localparam int NSQ  = qte_pkg::SQ_CELLS;
  localparam int LAT  = N + 35;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (AB - 2);
  localparam logic signed [PW-1:0] SMAX = PW'(32767);
  localparam logic signed [PW-1:0] SMIN = -PW'(32768);

  function automatic logic [15:0] sat16(input logic signed [PW-1:0] v);
    if (v > SMAX) return 16'h7FFF;
    if (v < SMIN) return 16'h8000;
    return v[15:0];
  endfunction

  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i & ~busy_o};
    end
  end

  assign busy_o = 1'b0;

  // products
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wy_q, p_zx_q, p_wz_q, p_xy_q, p_zz_q;

  always_ff @(posedge clk_i) begin
    p_wx_q <= quat_w_i * quat_x_i;
    p_yz_q <= quat_y_i * quat_z_i;
    p_xx_q <= quat_x_i * quat_x_i;
    p_yy_q <= quat_y_i * quat_y_i;
    p_wy_q <= quat_w_i * quat_y_i;
    p_zx_q <= quat_z_i * quat_x_i;
    p_wz_q <= quat_w_i * quat_z_i;
    p_xy_q <= quat_x_i * quat_y_i;
    p_zz_q <= quat_z_i * quat_z_i;
  end

  // doubled sums
  logic signed [SW-1:0] rs_d, rc_d, ps_d, ys_d, yc_d, ps_q;
  logic [qte_pkg::PAYW-1:0] pay2_q, pay3_q, pay4_q;

  assign rs_d = (SW'(p_wx_q) + SW'(p_yz_q)) <<< 1;
  assign rc_d = qte_pkg::Q_ONE - ((SW'(p_xx_q) + SW'(p_yy_q)) <<< 1);
  assign ps_d = (SW'(p_wy_q) - SW'(p_zx_q)) <<< 1;
  assign ys_d = (SW'(p_wz_q) + SW'(p_xy_q)) <<< 1;
  assign yc_d = qte_pkg::Q_ONE - ((SW'(p_yy_q) + SW'(p_zz_q)) <<< 1);

  always_ff @(posedge clk_i) begin
    ps_q   <= ps_d;
    pay2_q <= {(ps_d >= qte_pkg::Q_ONE) || (ps_d <= qte_pkg::Q_NEG),
               ps_d, rs_d, rc_d, ys_d, yc_d};
  end

  // 1 - sin^2 for the pitch cosine
  logic signed [SW-1:0]          ps_abs;
  logic [qte_pkg::MAGW-1:0]      mag;
  logic [2*qte_pkg::MAGW-1:0]    mm_q;
  logic [qte_pkg::RADW-1:0]      rad_q;

  assign ps_abs = ps_q[SW-1] ? -ps_q : ps_q;
  assign mag    = ps_abs[qte_pkg::MAGW-1:0];

  always_ff @(posedge clk_i) begin
    mm_q   <= (2*qte_pkg::MAGW)'(mag) * (2*qte_pkg::MAGW)'(mag);
    pay3_q <= pay2_q;
    rad_q  <= (qte_pkg::RADW'(1) << (2*qte_pkg::MAGW)) - qte_pkg::RADW'(mm_q);
    pay4_q <= pay3_q;
  end

  // square root chain
  logic [qte_pkg::RADW-1:0]  sq_rem  [NSQ+1];
  logic [qte_pkg::SQW-1:0]   sq_root [NSQ+1];
  logic [qte_pkg::PAYW-1:0]  sq_pay  [NSQ+1];

  assign sq_rem[0]  = rad_q;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = pay4_q;

  for (genvar j = 0; j < NSQ; j++) begin : g_sq
    qte_sqrt_cell #(.K(NSQ - 1 - j), .PW(qte_pkg::PAYW)) u_cell (
      .clk_i  (clk_i),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .pay_i  (sq_pay[j]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .pay_o  (sq_pay[j+1])
    );
  end

  // lane operands: 0 roll, 1 pitch, 2 yaw
  logic signed [SW-1:0] e_ps, e_rs, e_rc, e_ys, e_yc;
  logic                 e_clamp;
  logic signed [CW-1:0] ly [3];
  logic signed [CW-1:0] lx [3];

  assign {e_clamp, e_ps, e_rs, e_rc, e_ys, e_yc} = sq_pay[NSQ];
  assign ly[0] = CW'(e_rs);
  assign lx[0] = CW'(e_rc);
  assign ly[1] = CW'(e_ps);
  assign lx[1] = CW'(sq_root[NSQ]);
  assign ly[2] = CW'(e_ys);
  assign lx[2] = CW'(e_yc);

  logic signed [CW-1:0] cx [3][N+1];
  logic signed [CW-1:0] cy [3][N+1];
  logic signed [ZW-1:0] cz [3][N+1];
  logic                 czero [3][N+1];
  logic [N:0]           clp_q, neg_q;

  always_ff @(posedge clk_i) begin
    clp_q <= {clp_q[N-1:0], e_clamp};
    neg_q <= {neg_q[N-1:0], e_ps[SW-1]};
  end

  logic signed [PW-1:0] sc [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [CW-1:0] px_q, py_q;
    logic signed [ZW-1:0] pz_q;
    logic                 pzero_q;
    logic signed [PW-1:0] zx;

    always_ff @(posedge clk_i) begin
      pzero_q <= (lx[l] == '0) && (ly[l] == '0);
      if (lx[l][CW-1]) begin
        if (!ly[l][CW-1]) begin
          px_q <= ly[l];
          py_q <= -lx[l];
          pz_q <= QUARTER;
        end else begin
          px_q <= -ly[l];
          py_q <= lx[l];
          pz_q <= -QUARTER;
        end
      end else begin
        px_q <= lx[l];
        py_q <= ly[l];
        pz_q <= '0;
      end
    end

    assign cx[l][0]    = px_q;
    assign cy[l][0]    = py_q;
    assign cz[l][0]    = pz_q;
    assign czero[l][0] = pzero_q;

    for (genvar i = 0; i < N; i++) begin : g_stage
      qte_cordic_cell #(.I(i), .AB(AB), .ZW(ZW)) u_cell (
        .clk_i  (clk_i),
        .x_i    (cx[l][i]),
        .y_i    (cy[l][i]),
        .z_i    (cz[l][i]),
        .zero_i (czero[l][i]),
        .x_o    (cx[l][i+1]),
        .y_o    (cy[l][i+1]),
        .z_o    (cz[l][i+1]),
        .zero_o (czero[l][i+1])
      );
    end

    assign zx = czero[l][N] ? '0 : PW'(cz[l][N]);

    if (AB > 16) begin : g_dn
      localparam int D = AB - 16;
      localparam logic signed [PW-1:0] HALF = PW'(1) <<< (D - 1);
      assign sc[l] = (zx + HALF) >>> D;
    end else begin : g_up
      assign sc[l] = zx <<< (16 - AB);
    end
  end

  // output stage
  logic [15:0] roll_q, pitch_q, yaw_q;
  logic        clamped_q;

  always_ff @(posedge clk_i) begin
    roll_q    <= sat16(-sc[0]);
    yaw_q     <= sat16(-sc[2]);
    clamped_q <= clp_q[N];
    if (clp_q[N]) begin
      pitch_q <= neg_q[N] ? 16'hC000 : 16'h4000;
    end else begin
      pitch_q <= sat16(sc[1]);
    end
  end

  assign done_o          = vld_q[LAT-1];
  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign yaw_angle_o     = yaw_q;
  assign pitch_clamped_o = clamped_q;

  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("transaction did not complete at the fixed latency");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result strobe without a matching transaction");

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pitch_clamped_o) |->
      (pitch_angle_o == 16'sh4000 || pitch_angle_o == 16'shC000))
    else $error("clamped pitch is not a quarter turn");
endmodule

### hdl/qte_sqrt_cell.sv
// One bit of the restoring square root chain, with a payload passed along.
// Depends on qte_pkg.
module qte_sqrt_cell #(
  parameter int K   = 0,
  parameter int PW  = 1
) (
  input  logic                      clk_i,
  input  logic [qte_pkg::RADW-1:0]  rem_i,
  input  logic [qte_pkg::SQW-1:0]   root_i,
  input  logic [PW-1:0]             pay_i,
  output logic [qte_pkg::RADW-1:0]  rem_o,
  output logic [qte_pkg::SQW-1:0]   root_o,
  output logic [PW-1:0]             pay_o
);
  localparam int TW = qte_pkg::RADW + 3;

  logic [TW-1:0]                trial, rem_x;
  logic [qte_pkg::RADW-1:0]     rem_q;
  logic [qte_pkg::SQW-1:0]      root_q;
  logic [PW-1:0]                pay_q;

  assign rem_x = TW'(rem_i);
  assign trial = (TW'(root_i) << (K + 1)) + (TW'(1) << (2 * K));

  always_ff @(posedge clk_i) begin
    pay_q <= pay_i;
    if (rem_x >= trial) begin
      rem_q  <= qte_pkg::RADW'(rem_x - trial);
      root_q <= root_i | (qte_pkg::SQW'(1) << K);
    end else begin
      rem_q  <= rem_i;
      root_q <= root_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign pay_o  = pay_q;
endmodule

### hdl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// Depends on qte_pkg for widths and the arctangent constants.
module qte_cordic_cell #(
  parameter int I  = 0,
  parameter int AB = qte_pkg::ANGLE_BITS_DEF,
  parameter int ZW = qte_pkg::ANGLE_BITS_DEF + 2
) (
  input  logic                           clk_i,
  input  logic signed [qte_pkg::CW-1:0]  x_i,
  input  logic signed [qte_pkg::CW-1:0]  y_i,
  input  logic signed [ZW-1:0]           z_i,
  input  logic                           zero_i,
  output logic signed [qte_pkg::CW-1:0]  x_o,
  output logic signed [qte_pkg::CW-1:0]  y_o,
  output logic signed [ZW-1:0]           z_o,
  output logic                           zero_o
);
  localparam logic signed [ZW-1:0] ATC = ZW'(qte_pkg::atan_const(I, AB));

  logic signed [qte_pkg::CW-1:0] dx, dy, x_q, y_q;
  logic signed [ZW-1:0]          z_q;
  logic                          zero_q;

  assign dx = y_i >>> I;
  assign dy = x_i >>> I;

  always_ff @(posedge clk_i) begin
    zero_q <= zero_i;
    if (!y_i[qte_pkg::CW-1]) begin
      x_q <= x_i + dx;
      y_q <= y_i - dy;
      z_q <= z_i + ATC;
    end else begin
      x_q <= x_i - dx;
      y_q <= y_i + dy;
      z_q <= z_i - ATC;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign zero_o = zero_q;
endmodule
